// ----- sv/ssa_pkg.sv -----
// ---------------------------------------------------------------------------
// ssa_pkg
// Shared types and codes of the session stream allocator.
// ---------------------------------------------------------------------------
package ssa_pkg;

  // Defaults for the stream map geometry
  localparam int MAP_WORDS_DEF = 4;
  localparam int WORD_BITS_DEF = 64;

  // Queue depths
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  // Packet kinds
  localparam logic [3:0] K_CONNECT     = 4'd0;
  localparam logic [3:0] K_CONNECT_ACK = 4'd1;
  localparam logic [3:0] K_PING        = 4'd2;
  localparam logic [3:0] K_PONG        = 4'd3;
  localparam logic [3:0] K_OPEN        = 4'd4;
  localparam logic [3:0] K_OPEN_ACK    = 4'd5;
  localparam logic [3:0] K_CLOSE       = 4'd6;
  localparam logic [3:0] K_PUBLISH     = 4'd7;
  localparam logic [3:0] K_ERROR       = 4'd8;

  // Register indexes
  localparam logic [1:0] REG_MAGIC   = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_START   = 2'd2;

  typedef enum logic [1:0] {
    ST_INIT        = 2'd0,
    ST_CONNECTING  = 2'd1,
    ST_ESTABLISHED = 2'd2,
    ST_CLOSED      = 2'd3
  } state_t;

  // Classified operation
  typedef enum logic [2:0] {
    OP_CONNECT,
    OP_CONNECT_ACK,
    OP_PING,
    OP_OPEN,
    OP_CLOSE,
    OP_QUIET,
    OP_BAD
  } op_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] stream_num;
  } item_t;

  typedef struct packed {
    logic [3:0]  resp_kind;
    logic [7:0]  resp_stream_id;
    logic [31:0] resp_magic;
    logic [7:0]  resp_version;
    logic [7:0]  resp_flags;
    logic [15:0] resp_payload_len;
    logic [1:0]  session_state;
    logic [8:0]  open_count;
  } result_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] stream_num;
  } cmd_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [7:0]  version;
    logic        start_wr;
    logic        start_val;
  } cfg_t;

endpackage

// ----- sv/session_stream_allocator_core.sv -----
// ---------------------------------------------------------------------------
// session_stream_allocator_core
// Server session engine: classifies headers, tracks session and streams.
// ---------------------------------------------------------------------------
// Throughput: one header per cycle while the command queue is not full; the
//   back stage applies one command a cycle while the response queue is not
//   full, with the find-first-free search over the stream map.
// Reset (rst, synchronous): clears queues, stream map and open count, loads
//   registers with their defaults and the session with init. No clearing pass.
// ---------------------------------------------------------------------------
module session_stream_allocator_core
  import ssa_pkg::*;
#(
  parameter int MAP_WORDS = MAP_WORDS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // header input queue side
  input  logic        push,
  output logic        full,
  input  item_t       item,
  // response output queue side
  input  logic        pop,
  output logic        empty,
  output result_t     result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] magic_word;
  logic [7:0]  protocol_version;
  logic        start_connecting;
  logic        cfg_wr;
  logic [1:0]  reg_idx;
  cfg_t        cfg;

  logic        cmd_pop;
  logic        cmd_empty;
  cmd_t        cmd;
  logic        res_full;
  logic        res_push;
  result_t     res;

  // Register file: one word per register, index from paddr[3:2]
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word       <= '0;
      protocol_version <= 8'd1;
      start_connecting <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MAGIC:   magic_word       <= pwdata;
        REG_VERSION: protocol_version <= pwdata[7:0];
        REG_START:   start_connecting <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAGIC:   prdata = magic_word;
      REG_VERSION: prdata = {24'b0, protocol_version};
      REG_START:   prdata = {31'b0, start_connecting};
      default:     prdata = '0;
    endcase
  end

  // A start write also reloads the session state in the back stage
  assign cfg.magic     = magic_word;
  assign cfg.version   = protocol_version;
  assign cfg.start_wr  = cfg_wr && (reg_idx == REG_START);
  assign cfg.start_val = pwdata[0];

  // Front: classify and hold commands until the back stage takes them
  ssa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  // Back: apply each command, emit a response word when one is due
  ssa_back #(
    .MAP_WORDS (MAP_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Response queue: decouples the back stage from the consumer
  ssa_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res),
    .pop   (pop),
    .empty (empty),
    .rdata (result)
  );

endmodule

// ----- sv/ssa_fifo.sv -----
// ---------------------------------------------------------------------------
// ssa_fifo
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module ssa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/ssa_front.sv -----
// ---------------------------------------------------------------------------
// ssa_front
// Accepts headers, classifies the kind and queues the command.
// ---------------------------------------------------------------------------
module ssa_front
  import ssa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  input  logic  cmd_pop,
  output logic  cmd_empty,
  output cmd_t  cmd
);

  cmd_t cmd_in;

  always_comb begin
    cmd_in.stream_num = item.stream_num;
    unique case (item.kind)
      K_CONNECT:           cmd_in.op = OP_CONNECT;
      K_CONNECT_ACK:       cmd_in.op = OP_CONNECT_ACK;
      K_PING:              cmd_in.op = OP_PING;
      K_OPEN:              cmd_in.op = OP_OPEN;
      K_CLOSE:             cmd_in.op = OP_CLOSE;
      K_PUBLISH, K_ERROR:  cmd_in.op = OP_QUIET;
      default:             cmd_in.op = OP_BAD;
    endcase
  end

  ssa_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd)
  );

endmodule

// ----- sv/ssa_back.sv -----
// ---------------------------------------------------------------------------
// ssa_back
// Executes commands against session state, stream map and open count.
// ---------------------------------------------------------------------------
module ssa_back
  import ssa_pkg::*;
#(
  parameter int MAP_WORDS = MAP_WORDS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    cmd_empty,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  localparam int MAP_BITS = MAP_WORDS * WORD_BITS;
  localparam logic [MAP_BITS-1:0] ONE_BIT = MAP_BITS'(1);

  state_t              state;
  state_t              state_next;
  logic [MAP_BITS-1:0] stream_map;
  logic [MAP_BITS-1:0] stream_map_next;
  logic [8:0]          stream_count;
  logic [8:0]          stream_count_next;

  logic                fire;
  logic [MAP_BITS-1:0] free_bits;
  logic [MAP_BITS-1:0] lowest;
  logic                any_free;
  logic [7:0]          lowest_idx;
  logic [MAP_BITS-1:0] clr_mask;
  logic [8:0]          count_dec;
  logic [8:0]          count_inc;
  logic                answer;
  logic [3:0]          ans_kind;
  logic [7:0]          ans_sid;

  assign fire    = !cmd_empty && !res_full;
  assign cmd_pop = fire;

  // Lowest free stream: isolate the lowest set bit of the free map
  assign free_bits = ~stream_map;
  assign lowest    = free_bits & (~free_bits + ONE_BIT);
  assign any_free  = |free_bits;

  always_comb begin
    lowest_idx = '0;
    for (int i = 0; i < MAP_BITS; i++) begin
      if (lowest[i]) begin
        lowest_idx = lowest_idx | 8'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAP_BITS; i++) begin
      clr_mask[i] = (int'(cmd.stream_num) == i);
    end
  end

  assign count_dec = (stream_count == '0) ? '0 : stream_count - 9'd1;
  assign count_inc = (stream_count == 9'h1FF) ? stream_count : stream_count + 9'd1;

  // Next state
  always_comb begin
    state_next = state;
    if (cfg.start_wr) begin
      state_next = cfg.start_val ? ST_CONNECTING : ST_INIT;
    end else if (fire) begin
      unique case (state)
        ST_INIT: begin
          if (cmd.op == OP_CONNECT) state_next = ST_ESTABLISHED;
        end
        ST_CONNECTING: begin
          if (cmd.op == OP_CONNECT_ACK) state_next = ST_ESTABLISHED;
        end
        ST_ESTABLISHED: begin
          if (cmd.op == OP_CLOSE && count_dec == '0) state_next = ST_CLOSED;
        end
        ST_CLOSED: begin
          state_next = ST_INIT;
        end
      endcase
    end
  end

  // Map, count and answer
  always_comb begin
    stream_map_next   = stream_map;
    stream_count_next = stream_count;
    answer            = 1'b0;
    ans_kind          = K_ERROR;
    ans_sid           = cmd.stream_num;
    if (fire) begin
      unique case (state)
        ST_INIT: begin
          if (cmd.op == OP_CONNECT) begin
            stream_map_next   = stream_map | ONE_BIT;
            stream_count_next = 9'd1;
            answer            = 1'b1;
            ans_kind          = K_CONNECT_ACK;
            ans_sid           = '0;
          end
        end
        ST_ESTABLISHED: begin
          unique case (cmd.op)
            OP_PING: begin
              answer   = 1'b1;
              ans_kind = K_PONG;
            end
            OP_OPEN: begin
              answer = 1'b1;
              if (any_free) begin
                stream_map_next   = stream_map | lowest;
                stream_count_next = count_inc;
                ans_kind          = K_OPEN_ACK;
                ans_sid           = lowest_idx;
              end
            end
            OP_CLOSE: begin
              stream_map_next   = stream_map & ~clr_mask;
              stream_count_next = count_dec;
            end
            OP_QUIET: begin
              answer = 1'b0;
            end
            default: begin
              answer = 1'b1;
            end
          endcase
        end
        default: begin
          answer = 1'b0;
        end
      endcase
    end
  end

  assign res_push             = fire && answer;
  assign res.resp_kind        = ans_kind;
  assign res.resp_stream_id   = ans_sid;
  assign res.resp_magic       = cfg.magic;
  assign res.resp_version     = cfg.version;
  assign res.resp_flags       = '0;
  assign res.resp_payload_len = '0;
  assign res.session_state    = state_next;
  assign res.open_count       = stream_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      stream_map   <= '0;
      stream_count <= '0;
    end else begin
      state        <= state_next;
      stream_map   <= stream_map_next;
      stream_count <= stream_count_next;
    end
  end

endmodule

// ----- sv/ssa_checker.sv -----
// ---------------------------------------------------------------------------
// ssa_checker
// Port-level checks of the session stream allocator.
// ---------------------------------------------------------------------------
module ssa_checker
  import ssa_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    empty,
  input result_t result
);

  // Reset drops all queued words
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // Every response word carries the established session state
  a_resp_state: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.session_state == ST_ESTABLISHED))
    else $error("response outside established session");

  // Only the four answer kinds are produced
  a_resp_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.resp_kind == K_PONG || result.resp_kind == K_OPEN_ACK ||
                result.resp_kind == K_CONNECT_ACK || result.resp_kind == K_ERROR))
    else $error("unexpected response kind");

  // Flags and length stay zero
  a_resp_fields: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.resp_flags == '0 && result.resp_payload_len == '0))
    else $error("bad response header fields");

endmodule

bind session_stream_allocator_core ssa_checker u_ssa_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the session stream allocator core. A short table
// of headers covers every packet kind and the special cases of the init,
// established and closed states; random traffic shaped by the predicted
// state then drives the engine through connect, open, close, map-full and
// reconnect cycles under several register settings. Every response word is
// compared field by field with an in-bench prediction of the session engine.
// ---------------------------------------------------------------------------
module tb_top;
  import ssa_pkg::*;

  // Stream map geometry and predictor limits
  localparam int         NSTREAMS    = MAP_WORDS_DEF * WORD_BITS_DEF;
  localparam logic [8:0] CNT_MAX     = 9'd511;
  // Packet kinds with no name in the package
  localparam logic [3:0] K_OTHER     = 4'd9;
  localparam logic [3:0] K_TOP       = 4'd15;
  // Register defaults after reset
  localparam logic [31:0] RST_MAGIC   = 32'h0;
  localparam logic [7:0]  RST_VERSION = 8'h01;
  // Cycles to let the command queue drain after the last response
  localparam int SETTLE      = 16;
  // Watchdog: cycles with no handshake at all before the run is abandoned
  localparam int QUIET_LIMIT = 4000;

  // Clock and DUT ports; every input starts at a known value
  logic        clk;
  logic        rst     = 1'b1;
  logic        push    = 1'b0;
  logic        full;
  item_t       item    = '0;
  logic        pop     = 1'b0;
  logic        empty;
  result_t     result;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  session_stream_allocator_core dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .pop     (pop),
    .empty   (empty),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted registers and session state, mirrored from reset onward
  logic [31:0]         cfg_magic   = RST_MAGIC;
  logic [7:0]          cfg_version = RST_VERSION;
  logic                cfg_start   = 1'b0;
  state_t              sess_st     = ST_INIT;
  logic [NSTREAMS-1:0] stream_bits = '0;
  logic [8:0]          open_cnt    = '0;

  // Response words predicted but not yet popped, oldest first
  result_t pending_words[$];

  int fail_count   = 0;
  int quiet_cycles = 0;
  int stall_left   = 0;
  bit tx_gaps      = 1'b1;
  bit rx_gaps      = 1'b1;

  // Directed table: one header per row, with a typed answer where obvious
  typedef struct {
    item_t   hdr;
    bit      typed;
    result_t want;
  } dir_row_t;

  dir_row_t dir_tab[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Build a response word from the current predicted registers and state
  function automatic result_t resp_word(logic [3:0] k, logic [7:0] sid);
    result_t w;
    w                  = '0;
    w.resp_kind        = k;
    w.resp_stream_id   = sid;
    w.resp_magic       = cfg_magic;
    w.resp_version     = cfg_version;
    w.session_state    = sess_st;
    w.open_count       = open_cnt;
    return w;
  endfunction

  // Response word as it must look under the reset register values
  function automatic result_t typed_word(logic [3:0] k, logic [7:0] sid,
                                         state_t st, logic [8:0] cnt);
    result_t w;
    w                = '0;
    w.resp_kind      = k;
    w.resp_stream_id = sid;
    w.resp_magic     = RST_MAGIC;
    w.resp_version   = RST_VERSION;
    w.session_state  = st;
    w.open_count     = cnt;
    return w;
  endfunction

  // Advance the session by one header; return 1 when it answers
  function automatic bit session_step(input item_t hdr, output result_t w);
    int slot;
    bit hit;
    hit  = 1'b0;
    slot = -1;
    w    = '0;
    case (sess_st)
      ST_INIT: begin
        if (hdr.kind == K_CONNECT) begin
          stream_bits[0] = 1'b1;
          open_cnt       = 9'd1;
          sess_st        = ST_ESTABLISHED;
          w              = resp_word(K_CONNECT_ACK, 8'd0);
          hit            = 1'b1;
        end
      end
      ST_CONNECTING: begin
        if (hdr.kind == K_CONNECT_ACK) sess_st = ST_ESTABLISHED;
      end
      ST_CLOSED: begin
        sess_st = ST_INIT;
      end
      default: begin
        hit = 1'b1;
        case (hdr.kind)
          K_PING: begin
            w = resp_word(K_PONG, hdr.stream_num);
          end
          K_OPEN: begin
            // lowest free stream wins
            for (int i = NSTREAMS - 1; i >= 0; i--)
              if (!stream_bits[i]) slot = i;
            if (slot < 0) begin
              w = resp_word(K_ERROR, hdr.stream_num);
            end else begin
              stream_bits[slot] = 1'b1;
              if (open_cnt != CNT_MAX) open_cnt++;
              w = resp_word(K_OPEN_ACK, slot[7:0]);
            end
          end
          K_CLOSE: begin
            hit = 1'b0;
            stream_bits[hdr.stream_num] = 1'b0;
            if (open_cnt != 0) open_cnt--;
            if (open_cnt == 0) sess_st = ST_CLOSED;
          end
          K_PUBLISH, K_ERROR: begin
            hit = 1'b0;
          end
          default: begin
            w = resp_word(K_ERROR, hdr.stream_num);
          end
        endcase
      end
    endcase
    return hit;
  endfunction

  // Pick the next random header, steered by the predicted session state
  function automatic item_t pick_item(int open_pct);
    item_t hdr;
    int    r;
    int    hi;
    hdr.stream_num = 8'($urandom_range(0, 255));
    hdr.kind       = 4'($urandom_range(0, 15));
    r              = $urandom_range(0, 99);
    hi             = -1;
    case (sess_st)
      ST_INIT:       if (r < 70) hdr.kind = K_CONNECT;
      ST_CONNECTING: if (r < 60) hdr.kind = K_CONNECT_ACK;
      ST_ESTABLISHED: begin
        if (r < open_pct) begin
          hdr.kind = K_OPEN;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            hdr.kind = K_CLOSE;
            // aim most closes at streams that are actually open
            for (int i = 0; i < NSTREAMS; i++)
              if (stream_bits[i]) hi = i;
            if (hi >= 0 && $urandom_range(0, 4) != 0) begin
              for (int t = 0; t < 4; t++) begin
                hdr.stream_num = 8'($urandom_range(0, hi));
                if (stream_bits[hdr.stream_num]) break;
              end
            end
          end else if (r < 65) begin
            hdr.kind = K_PING;
          end else if (r < 75) begin
            hdr.kind = K_PUBLISH;
          end
        end
      end
      default: ;
    endcase
    return hdr;
  endfunction

  task automatic add_row(logic [3:0] k, logic [7:0] sid);
    dir_row_t row;
    row.hdr.kind       = k;
    row.hdr.stream_num = sid;
    row.typed          = 1'b0;
    row.want           = '0;
    dir_tab.push_back(row);
  endtask

  task automatic add_typed(logic [3:0] k, logic [7:0] sid, result_t w);
    dir_row_t row;
    row.hdr.kind       = k;
    row.hdr.stream_num = sid;
    row.typed          = 1'b1;
    row.want           = w;
    dir_tab.push_back(row);
  endtask

  // Push one header, with an optional random gap before it; hold until it
  // is taken, then predict its answer. The caller lowers push when done.
  task automatic send_item(input item_t hdr, input bit typed, input result_t want);
    result_t w;
    bit      got;
    int      n;
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      n = $urandom_range(1, 3);
      repeat (n) @(posedge clk);
    end
    push <= 1'b1;
    item <= hdr;
    do @(posedge clk); while (full !== 1'b0);
    got = session_step(hdr, w);
    if (typed) pending_words.push_back(want);
    else if (got) pending_words.push_back(w);
  endtask

  // Drop push and wait until every predicted word has been popped
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  // Drain, then let headers that give no answer leave the pipeline
  task automatic settle_idle();
    drain_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, access cycle, done when pready is seen
  task automatic apb_xfer(input logic [1:0] idx, input bit wr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Read a register back and compare it with the predicted value
  task automatic check_reg(input logic [1:0] idx);
    logic [31:0] got;
    logic [31:0] want;
    bit          ok;
    apb_xfer(idx, 1'b0, '0, got);
    case (idx)
      REG_MAGIC: begin
        want = cfg_magic;
        ok   = (got == want);
      end
      REG_VERSION: begin
        want = {24'h0, cfg_version};
        ok   = (got[7:0] == cfg_version);
      end
      default: begin
        want = {31'h0, cfg_start};
        ok   = (got[0] == cfg_start);
      end
    endcase
    if (!ok) begin
      $display("%0t: register %0d read: expected %h, actual %h", $time, idx, want, got);
      fail_count++;
    end
  endtask

  // Write a register, mirror it in the predictor, read it back
  task automatic config_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] unused;
    apb_xfer(idx, 1'b1, val, unused);
    case (idx)
      REG_MAGIC:   cfg_magic   = val;
      REG_VERSION: cfg_version = val[7:0];
      default: begin
        // a write to the start register also reloads the session state
        cfg_start = val[0];
        sess_st   = val[0] ? ST_CONNECTING : ST_INIT;
      end
    endcase
    check_reg(idx);
  endtask

  // One setting of the registers followed by a burst of random headers
  task automatic run_phase(input logic [31:0] magic, input logic [7:0] ver,
                           input bit start, input int n, input int open_pct,
                           input bit gaps);
    settle_idle();
    config_reg(REG_MAGIC, magic);
    config_reg(REG_VERSION, {24'h0, ver});
    config_reg(REG_START, {31'h0, start});
    tx_gaps = gaps;
    rx_gaps = gaps;
    for (int i = 0; i < n; i++) begin
      // hold off once per phase until every answer is home
      if (i == n / 2) drain_results();
      send_item(pick_item(open_pct), 1'b0, '0);
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Response side: check each popped word, then decide on the next pop
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected response word: expected none, actual %h", $time, result);
          fail_count++;
        end else begin
          want = pending_words.pop_front();
          cmp_field("resp_kind", 32'(want.resp_kind), 32'(result.resp_kind));
          cmp_field("resp_stream_id", 32'(want.resp_stream_id),
                    32'(result.resp_stream_id));
          cmp_field("resp_magic", want.resp_magic, result.resp_magic);
          cmp_field("resp_version", 32'(want.resp_version), 32'(result.resp_version));
          cmp_field("resp_flags", 32'(want.resp_flags), 32'(result.resp_flags));
          cmp_field("resp_payload_len", 32'(want.resp_payload_len),
                    32'(result.resp_payload_len));
          cmp_field("session_state", 32'(want.session_state),
                    32'(result.session_state));
          cmp_field("open_count", 32'(want.open_count), 32'(result.open_count));
        end
      end
      // stall in random bursts
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog bookkeeping: any handshake resets the quiet count
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus: reset, register check, directed table, random phases
  initial begin
    // Init: anything but connect is ignored, connect answers on stream 0
    add_row(K_PING, 8'hFF);
    add_row(K_OPEN, 8'h00);
    add_typed(K_CONNECT, 8'hFF, typed_word(K_CONNECT_ACK, 8'h00, ST_ESTABLISHED, 9'd1));
    // Established: ping echoes the stream, opens take the lowest free
    add_typed(K_PING, 8'hFF, typed_word(K_PONG, 8'hFF, ST_ESTABLISHED, 9'd1));
    add_typed(K_PING, 8'h00, typed_word(K_PONG, 8'h00, ST_ESTABLISHED, 9'd1));
    add_row(K_OPEN, 8'h00);
    add_row(K_OPEN, 8'h80);
    // Kinds a server never takes are answered with an error
    add_typed(K_PONG, 8'h00, typed_word(K_ERROR, 8'h00, ST_ESTABLISHED, 9'd3));
    add_typed(K_OPEN_ACK, 8'h7F, typed_word(K_ERROR, 8'h7F, ST_ESTABLISHED, 9'd3));
    add_typed(K_CONNECT, 8'h55, typed_word(K_ERROR, 8'h55, ST_ESTABLISHED, 9'd3));
    add_typed(K_CONNECT_ACK, 8'hAA, typed_word(K_ERROR, 8'hAA, ST_ESTABLISHED, 9'd3));
    add_typed(K_OTHER, 8'h01, typed_word(K_ERROR, 8'h01, ST_ESTABLISHED, 9'd3));
    add_typed(K_TOP, 8'hFE, typed_word(K_ERROR, 8'hFE, ST_ESTABLISHED, 9'd3));
    // Publish and error are silent
    add_row(K_PUBLISH, 8'h01);
    add_row(K_ERROR, 8'h02);
    // Close open streams and one stream that was never opened; the count then reaches zero
    add_row(K_CLOSE, 8'h02);
    add_row(K_CLOSE, 8'hFF);
    add_row(K_PING, 8'h03);
    add_row(K_CLOSE, 8'h01);
    // Closed: any header returns to init; then reconnect and close again
    add_row(K_PING, 8'h04);
    add_row(K_CONNECT_ACK, 8'h05);
    add_typed(K_CONNECT, 8'h00, typed_word(K_CONNECT_ACK, 8'h00, ST_ESTABLISHED, 9'd1));
    add_row(K_CLOSE, 8'h00);
    add_row(K_CLOSE, 8'h00);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers must come up with their defaults
    check_reg(REG_MAGIC);
    check_reg(REG_VERSION);
    check_reg(REG_START);

    foreach (dir_tab[i]) send_item(dir_tab[i].hdr, dir_tab[i].typed, dir_tab[i].want);

    // extremes of the registers, a connecting start, a map-filling run,
    // and a final stretch with no idling on either side
    run_phase(32'hFFFF_FFFF, 8'h00, 1'b0, 400, 40, 1'b1);
    run_phase($urandom, 8'hFF, 1'b1, 400, 30, 1'b1);
    run_phase(32'h0, 8'($urandom_range(0, 255)), 1'b0, 550, 85, 1'b1);
    run_phase($urandom, 8'($urandom_range(0, 255)), 1'b1, 450, 45, 1'b0);

    settle_idle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
